/* rtl/core/png_coc_pkg.sv */
// Shared types, chunk codes and result codes for the PNG chunk order checker.
package png_coc_pkg;

   // Chunk type codes, first character in the most significant byte.
   localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
   localparam logic [31:0] TYPE_PLTE = 32'h504C_5445;
   localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
   localparam logic [31:0] TYPE_BKGD = 32'h624B_4744;
   localparam logic [31:0] TYPE_GAMA = 32'h6741_4D41;
   localparam logic [31:0] TYPE_CHRM = 32'h6348_524D;
   localparam logic [31:0] TYPE_HIST = 32'h6849_5354;
   localparam logic [31:0] TYPE_PHYS = 32'h7048_5973;
   localparam logic [31:0] TYPE_TRNS = 32'h7452_4E53;
   localparam logic [31:0] TYPE_SBIT = 32'h7342_4954;

   // Header chunk limits.
   localparam logic [30:0] HEADER_LENGTH  = 31'd13;
   localparam logic [7:0]  MAX_COLOR_TYPE = 8'd7;

   // Bit positions in the ancillary seen vector.
   localparam int ANC_COUNT = 7;
   localparam int SLOT_BKGD = 0;
   localparam int SLOT_GAMA = 1;
   localparam int SLOT_CHRM = 2;
   localparam int SLOT_HIST = 3;
   localparam int SLOT_PHYS = 4;
   localparam int SLOT_TRNS = 5;
   localparam int SLOT_SBIT = 6;

   // Header placement codes.
   localparam logic [1:0] HERR_NONE          = 2'd0;
   localparam logic [1:0] HERR_FIRST_NOT_HDR = 2'd1;
   localparam logic [1:0] HERR_SEVERAL_HDR   = 2'd2;
   localparam logic [1:0] HERR_HDR_NOT_FIRST = 2'd3;

   // Chunk error codes.
   localparam logic [2:0] CERR_NONE           = 3'd0;
   localparam logic [2:0] CERR_REPEATED       = 3'd1;
   localparam logic [2:0] CERR_MISPLACED      = 3'd2;
   localparam logic [2:0] CERR_DATA_GAP       = 3'd3;
   localparam logic [2:0] CERR_PALETTE_MISSING = 3'd4;

   // Classification of one chunk.
   typedef struct packed {
      logic                 is_hdr;
      logic                 is_plte;
      logic                 is_idat;
      logic [ANC_COUNT-1:0] anc;
      logic                 hdr_valid;
      logic                 palette_bit;
   } chunk_class_type;

   // One result.
   typedef struct packed {
      logic [1:0]  header_error;
      logic [2:0]  chunk_error;
      logic [15:0] error_total;
   } result_type;

endpackage

/* rtl/core/png_coc_decode.sv */
// Chunk type decoder: classifies one chunk and checks the header fields.
module png_coc_decode
   import png_coc_pkg::*;
(
   input  logic [31:0]     chunk_type,
   input  logic [30:0]     data_length,
   input  logic [7:0]      header_color_type,
   output chunk_class_type cls
);

   // Match the type code against the known chunks.
   always_comb begin
      cls = '0;
      case (chunk_type)
         TYPE_IHDR: cls.is_hdr = 1'b1;
         TYPE_PLTE: cls.is_plte = 1'b1;
         TYPE_IDAT: cls.is_idat = 1'b1;
         TYPE_BKGD: cls.anc[SLOT_BKGD] = 1'b1;
         TYPE_GAMA: cls.anc[SLOT_GAMA] = 1'b1;
         TYPE_CHRM: cls.anc[SLOT_CHRM] = 1'b1;
         TYPE_HIST: cls.anc[SLOT_HIST] = 1'b1;
         TYPE_PHYS: cls.anc[SLOT_PHYS] = 1'b1;
         TYPE_TRNS: cls.anc[SLOT_TRNS] = 1'b1;
         TYPE_SBIT: cls.anc[SLOT_SBIT] = 1'b1;
         default: cls.anc = '0;
      endcase
      // A well-formed header sets the palette flag for later chunks.
      cls.hdr_valid = cls.is_hdr && (data_length == HEADER_LENGTH) &&
                      (header_color_type <= MAX_COLOR_TYPE);
      cls.palette_bit = header_color_type[0];
   end

endmodule

/* rtl/core/png_coc_track.sv */
// Ordering state and checks: holds the seen flags and forms one result per chunk.
module png_coc_track
   import png_coc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  chunk_class_type cls,
   output result_type      result
);

   logic                 awaiting_first_ff, awaiting_first_in;
   logic                 seen_header_ff, seen_header_in;
   logic                 seen_palette_ff, seen_palette_in;
   logic                 seen_data_ff, seen_data_in;
   logic                 data_closed_ff, data_closed_in;
   logic                 data_gap_reported_ff, data_gap_reported_in;
   logic [ANC_COUNT-1:0] seen_anc_ff, seen_anc_in;
   logic                 uses_palette_ff, uses_palette_in;
   logic [15:0]          error_counter_ff, error_counter_in;

   logic                 early;
   logic [ANC_COUNT-1:0] place_ok;
   logic [1:0]           herr;
   logic [2:0]           cerr;
   logic [1:0]           inc;
   logic [16:0]          sum;

   // Checks for the chunk at hand and the state it leaves behind.
   always_comb begin
      awaiting_first_in    = awaiting_first_ff;
      seen_header_in       = seen_header_ff;
      seen_palette_in      = seen_palette_ff;
      seen_data_in         = seen_data_ff;
      data_closed_in       = data_closed_ff;
      data_gap_reported_in = data_gap_reported_ff;
      seen_anc_in          = seen_anc_ff;
      uses_palette_in      = uses_palette_ff;
      herr                 = HERR_NONE;
      cerr                 = CERR_NONE;

      // Header placement.
      if (awaiting_first_ff) begin
         awaiting_first_in = 1'b0;
         if (!cls.is_hdr) begin
            herr = HERR_FIRST_NOT_HDR;
         end else begin
            seen_header_in = 1'b1;
         end
      end else if (cls.is_hdr) begin
         if (seen_header_ff) begin
            herr = HERR_SEVERAL_HDR;
         end else begin
            herr = HERR_HDR_NOT_FIRST;
            seen_header_in = 1'b1;
         end
      end

      // Palette repeats.
      if (cls.is_plte) begin
         if (seen_palette_ff) begin
            cerr = CERR_REPEATED;
         end else begin
            seen_palette_in = 1'b1;
         end
      end

      // The data run; any other chunk closes an open run.
      if (cls.is_idat) begin
         if (data_closed_ff && !data_gap_reported_ff) begin
            cerr = CERR_DATA_GAP;
            data_gap_reported_in = 1'b1;
         end else begin
            if (uses_palette_ff && !seen_palette_ff) begin
               cerr = CERR_PALETTE_MISSING;
            end
            seen_data_in = 1'b1;
         end
      end else if (seen_data_ff && !data_closed_ff) begin
         data_closed_in = 1'b1;
      end

      // Allowed places of each ancillary chunk.
      early = seen_header_ff && !seen_data_ff;
      place_ok = {ANC_COUNT{early}};
      place_ok[SLOT_BKGD] = early && (seen_palette_ff || !uses_palette_ff);
      place_ok[SLOT_TRNS] = early && (seen_palette_ff || !uses_palette_ff);
      place_ok[SLOT_GAMA] = early && !seen_palette_ff;
      place_ok[SLOT_CHRM] = early && !seen_palette_ff;
      place_ok[SLOT_SBIT] = early && !seen_palette_ff;
      place_ok[SLOT_HIST] = early && seen_palette_ff;

      // A misplaced chunk still counts as seen.
      if (|(cls.anc & seen_anc_ff)) begin
         cerr = CERR_REPEATED;
      end else if (|cls.anc) begin
         if (|(cls.anc & ~place_ok)) begin
            cerr = CERR_MISPLACED;
         end
         seen_anc_in = seen_anc_ff | cls.anc;
      end

      // Saturating error count, up to two per chunk.
      inc = {1'b0, herr != HERR_NONE} + {1'b0, cerr != CERR_NONE};
      sum = {1'b0, error_counter_ff} + {15'd0, inc};
      error_counter_in = sum[16] ? 16'hFFFF : sum[15:0];

      // The palette flag takes effect from the next chunk.
      if (cls.hdr_valid) begin
         uses_palette_in = cls.palette_bit;
      end

      result.header_error = herr;
      result.chunk_error  = cerr;
      result.error_total  = error_counter_in;
   end

   // State registers move only when a chunk passes to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_first_ff    <= 1'b1;
         seen_header_ff       <= 1'b0;
         seen_palette_ff      <= 1'b0;
         seen_data_ff         <= 1'b0;
         data_closed_ff       <= 1'b0;
         data_gap_reported_ff <= 1'b0;
         seen_anc_ff          <= '0;
         uses_palette_ff      <= 1'b0;
         error_counter_ff     <= '0;
      end else if (advance) begin
         awaiting_first_ff    <= awaiting_first_in;
         seen_header_ff       <= seen_header_in;
         seen_palette_ff      <= seen_palette_in;
         seen_data_ff         <= seen_data_in;
         data_closed_ff       <= data_closed_in;
         data_gap_reported_ff <= data_gap_reported_in;
         seen_anc_ff          <= seen_anc_in;
         uses_palette_ff      <= uses_palette_in;
         error_counter_ff     <= error_counter_in;
      end
   end

`ifndef ASSERT_OFF
   // The count never goes down outside reset.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> error_counter_ff >= $past(error_counter_ff))
      else $error("error counter decreased");

   // A reported gap implies the data run was closed.
   assert property (@(posedge clock) disable iff (reset)
      data_gap_reported_ff |-> data_closed_ff)
      else $error("gap reported without closed data run");

   // Header codes only for the first chunk or a header chunk.
   assert property (@(posedge clock) disable iff (reset)
      (herr != HERR_NONE) |-> (awaiting_first_ff || cls.is_hdr))
      else $error("header code on unrelated chunk");
`endif

endmodule

/* rtl/core/png_chunk_order_checker.sv */
// A request taken into the input register moves to the result register once that register is free.
// Throughput: one request per cycle, limited only by the result register and rsp_stall.
// The input register and the result register each hold one request.
// Reset (synchronous, active high) empties both registers and clears all seen flags
// and the error count; no clearing pass is needed.
module png_chunk_order_checker
   import png_coc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_chunk_type,
   input  logic [30:0] req_data_length,
   input  logic [7:0]  req_header_color_type,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_header_error,
   output logic [2:0]  rsp_chunk_error,
   output logic [15:0] rsp_error_total
);

   logic            in_valid_ff;
   logic [31:0]     in_type_ff;
   logic [30:0]     in_length_ff;
   logic [7:0]      in_color_ff;
   logic            rsp_valid_ff;
   result_type      rsp_ff;
   logic            advance;
   chunk_class_type cls;
   result_type      result;

   // A request moves on when the result register is empty or being drained.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_type_ff   <= req_chunk_type;
         in_length_ff <= req_data_length;
         in_color_ff  <= req_header_color_type;
      end
   end

   png_coc_decode u_decode (
      .chunk_type        (in_type_ff),
      .data_length       (in_length_ff),
      .header_color_type (in_color_ff),
      .cls               (cls)
   );

   png_coc_track u_track (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cls     (cls),
      .result  (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_header_error = rsp_ff.header_error;
   assign rsp_chunk_error  = rsp_ff.chunk_error;
   assign rsp_error_total  = rsp_ff.error_total;

`ifndef ASSERT_OFF
   // Back-pressure only while a request is held.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("stall with empty input register");

   // A request that moves on shows up as a result.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced request lost");

   // A stalled result is not overwritten.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !advance)
      else $error("stalled result overwritten");
`endif

endmodule

/* sim/png_chunk_order_checker_tb.sv */
// Self-checking testbench for the PNG chunk order checker: directed table and random runs.
module png_chunk_order_checker_tb
   import png_coc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Cycles without any accepted request or result before the run is abandoned.
   localparam int STALL_LIMIT = 500;
   localparam int RANDOM_CHUNKS = 1000;
   localparam int PAUSE_AT = 500;
   localparam int MAX_REPORTS = 100;
   // A chunk type that no check knows about.
   localparam logic [31:0] TYPE_TEXT = 32'h7445_5874;

   // One row of stimulus, with an optional hand-written result.
   typedef struct packed {
      logic [31:0] ctype;
      logic [30:0] clen;
      logic [7:0]  color;
      logic        pinned;
      result_type  want;
   } chunk_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_chunk_type = '0;
   logic [30:0] req_data_length = '0;
   logic [7:0]  req_header_color_type = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_header_error;
   logic [2:0]  rsp_chunk_error;
   logic [15:0] rsp_error_total;

   // Hand-written result travelling with the current request.
   logic        req_pinned = 1'b0;
   result_type  req_pinned_rsp = '0;

   // Predictor state.
   logic        first_pending;
   logic        got_header;
   logic        got_palette;
   logic        got_data;
   logic        run_closed;
   logic        gap_flagged;
   logic [ANC_COUNT-1:0] anc_seen;
   logic        palette_mode;
   logic [15:0] err_count;

   result_type    expected_results[$];
   chunk_row_type directed_rows[$];
   result_type    predicted;
   result_type    oldest;
   int            fail_count = 0;
   int            idle_cycles = 0;
   bit            calm = 1'b0;

   png_chunk_order_checker dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_chunk_type        (req_chunk_type),
      .req_data_length       (req_data_length),
      .req_header_color_type (req_header_color_type),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_header_error      (rsp_header_error),
      .rsp_chunk_error       (rsp_chunk_error),
      .rsp_error_total       (rsp_error_total)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Works out the result of one chunk and advances the ordering flags.
   task automatic predict_chunk(input logic [31:0] ctype, input logic [30:0] clen,
                                input logic [7:0] color, output result_type r);
      logic [1:0] herr;
      logic [2:0] cerr;
      logic       is_hdr;
      logic       early;
      logic       placed_ok;
      int         slot;
      herr = HERR_NONE;
      cerr = CERR_NONE;
      is_hdr = (ctype == TYPE_IHDR);
      placed_ok = 1'b1;

      // Header placement.
      if (first_pending) begin
         first_pending = 1'b0;
         if (!is_hdr) herr = HERR_FIRST_NOT_HDR;
         else got_header = 1'b1;
      end else if (is_hdr) begin
         if (got_header) begin
            herr = HERR_SEVERAL_HDR;
         end else begin
            herr = HERR_HDR_NOT_FIRST;
            got_header = 1'b1;
         end
      end

      if (ctype == TYPE_PLTE) begin
         if (got_palette) cerr = CERR_REPEATED;
         else got_palette = 1'b1;
      end

      // The data run: any other chunk closes it, and one late IDAT is flagged.
      if (ctype == TYPE_IDAT) begin
         if (run_closed && !gap_flagged) begin
            cerr = CERR_DATA_GAP;
            gap_flagged = 1'b1;
         end else begin
            if (palette_mode && !got_palette) cerr = CERR_PALETTE_MISSING;
            got_data = 1'b1;
         end
      end else if (got_data && !run_closed) begin
         run_closed = 1'b1;
      end

      case (ctype)
         TYPE_BKGD: slot = SLOT_BKGD;
         TYPE_GAMA: slot = SLOT_GAMA;
         TYPE_CHRM: slot = SLOT_CHRM;
         TYPE_HIST: slot = SLOT_HIST;
         TYPE_PHYS: slot = SLOT_PHYS;
         TYPE_TRNS: slot = SLOT_TRNS;
         TYPE_SBIT: slot = SLOT_SBIT;
         default:   slot = -1;
      endcase

      // Ancillary chunks: a misplaced one still counts as seen.
      if (slot >= 0) begin
         if (anc_seen[slot]) begin
            cerr = CERR_REPEATED;
         end else begin
            early = got_header && !got_data;
            case (slot)
               SLOT_BKGD, SLOT_TRNS: placed_ok = early && (got_palette || !palette_mode);
               SLOT_GAMA, SLOT_CHRM, SLOT_SBIT: placed_ok = early && !got_palette;
               SLOT_HIST: placed_ok = early && got_palette;
               default: placed_ok = early;
            endcase
            if (!placed_ok) cerr = CERR_MISPLACED;
            anc_seen[slot] = 1'b1;
         end
      end

      if (herr != HERR_NONE && err_count != 16'hFFFF) err_count = err_count + 16'd1;
      if (cerr != CERR_NONE && err_count != 16'hFFFF) err_count = err_count + 16'd1;

      // The palette flag only takes effect from the next chunk on.
      if (is_hdr && clen == HEADER_LENGTH && color <= MAX_COLOR_TYPE)
         palette_mode = color[0];

      r.header_error = herr;
      r.chunk_error = cerr;
      r.error_total = err_count;
   endtask

   task automatic add_row(input logic [31:0] ctype, input logic [30:0] clen,
                          input logic [7:0] color, input logic pinned,
                          input logic [1:0] herr, input logic [2:0] cerr,
                          input logic [15:0] total);
      chunk_row_type row;
      row.ctype = ctype;
      row.clen = clen;
      row.color = color;
      row.pinned = pinned;
      row.want.header_error = herr;
      row.want.chunk_error = cerr;
      row.want.error_total = total;
      directed_rows.push_back(row);
   endtask

   task automatic report_field(input string field, input int want, input int got);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      else if (fail_count == MAX_REPORTS + 1)
         $display("%0t ns: further mismatches are not shown", $time);
   endtask

   // Offers one request after a random gap and holds it until it is taken.
   task automatic send_chunk(input chunk_row_type row);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 12);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_chunk_type <= row.ctype;
      req_data_length <= row.clen;
      req_header_color_type <= row.color;
      req_pinned <= row.pinned;
      req_pinned_rsp <= row.want;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // Predict at each accepted request, check each accepted result, count idle cycles.
   always @(posedge clock) begin
      if (reset) begin
         first_pending = 1'b1;
         got_header = 1'b0;
         got_palette = 1'b0;
         got_data = 1'b0;
         run_closed = 1'b0;
         gap_flagged = 1'b0;
         anc_seen = '0;
         palette_mode = 1'b0;
         err_count = '0;
         idle_cycles = 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (req_valid && !req_stall) begin
            predict_chunk(req_chunk_type, req_data_length, req_header_color_type, predicted);
            if (req_pinned) expected_results.push_back(req_pinned_rsp);
            else expected_results.push_back(predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_field("unexpected result, error_total", -1, rsp_error_total);
            end else begin
               oldest = expected_results.pop_front();
               if (rsp_header_error !== oldest.header_error)
                  report_field("header_error", oldest.header_error, rsp_header_error);
               if (rsp_chunk_error !== oldest.chunk_error)
                  report_field("chunk_error", oldest.chunk_error, rsp_chunk_error);
               if (rsp_error_total !== oldest.error_total)
                  report_field("error_total", oldest.error_total, rsp_error_total);
            end
         end
      end
   end

   // Result side: stall for a random number of cycles before taking each result.
   initial begin
      int hold;
      forever begin
         hold = calm ? 0 : $urandom_range(0, 12);
         repeat (hold) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // Watchdog.
   initial begin
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("** png_chunk_order_checker: FAILED **");
      $finish;
   end

   initial begin
      chunk_row_type row;
      logic [31:0] rnd;
      int pick;

      // Directed table, walked from reset; pinned rows carry the result by hand.
      add_row(32'hFFFF_FFFF, 31'h7FFF_FFFF, 8'hFF, 1'b1, HERR_FIRST_NOT_HDR, CERR_NONE, 16'd1);
      add_row(TYPE_IHDR, HEADER_LENGTH, 8'd3, 1'b1, HERR_HDR_NOT_FIRST, CERR_NONE, 16'd2);
      add_row(TYPE_IHDR, HEADER_LENGTH, 8'hFF, 1'b1, HERR_SEVERAL_HDR, CERR_NONE, 16'd3);
      add_row(TYPE_IHDR, 31'h7FFF_FFFF, 8'd0, 1'b1, HERR_SEVERAL_HDR, CERR_NONE, 16'd4);
      add_row(TYPE_GAMA, 31'd0, 8'd0, 1'b0, HERR_NONE, CERR_NONE, 16'd0);
      add_row(TYPE_GAMA, 31'd0, 8'd0, 1'b1, HERR_NONE, CERR_REPEATED, 16'd5);
      add_row(TYPE_BKGD, 31'd6, 8'd0, 1'b1, HERR_NONE, CERR_MISPLACED, 16'd6);
      add_row(TYPE_HIST, 31'd8, 8'd0, 1'b1, HERR_NONE, CERR_MISPLACED, 16'd7);
      add_row(TYPE_BKGD, 31'd6, 8'd0, 1'b1, HERR_NONE, CERR_REPEATED, 16'd8);
      add_row(TYPE_IHDR, HEADER_LENGTH, 8'd2, 1'b1, HERR_SEVERAL_HDR, CERR_NONE, 16'd9);
      add_row(TYPE_TRNS, 31'd2, 8'd0, 1'b0, HERR_NONE, CERR_NONE, 16'd0);
      add_row(TYPE_CHRM, 31'd32, 8'd0, 1'b0, HERR_NONE, CERR_NONE, 16'd0);
      add_row(TYPE_SBIT, 31'd3, 8'd0, 1'b0, HERR_NONE, CERR_NONE, 16'd0);
      add_row(TYPE_PHYS, 31'd9, 8'd0, 1'b0, HERR_NONE, CERR_NONE, 16'd0);
      add_row(TYPE_IHDR, HEADER_LENGTH, 8'd7, 1'b1, HERR_SEVERAL_HDR, CERR_NONE, 16'd10);
      add_row(TYPE_IDAT, 31'd100, 8'd0, 1'b1, HERR_NONE, CERR_PALETTE_MISSING, 16'd11);
      add_row(TYPE_IDAT, 31'd0, 8'd0, 1'b1, HERR_NONE, CERR_PALETTE_MISSING, 16'd12);
      add_row(32'h0000_0000, 31'd0, 8'd0, 1'b1, HERR_NONE, CERR_NONE, 16'd12);
      add_row(TYPE_IDAT, 31'd5, 8'd0, 1'b1, HERR_NONE, CERR_DATA_GAP, 16'd13);
      add_row(TYPE_IDAT, 31'd5, 8'd0, 1'b1, HERR_NONE, CERR_PALETTE_MISSING, 16'd14);
      add_row(TYPE_PLTE, 31'd48, 8'd0, 1'b0, HERR_NONE, CERR_NONE, 16'd0);
      add_row(TYPE_PLTE, 31'd48, 8'd0, 1'b1, HERR_NONE, CERR_REPEATED, 16'd15);
      add_row(TYPE_IDAT, 31'd5, 8'd0, 1'b0, HERR_NONE, CERR_NONE, 16'd0);
      add_row(TYPE_PHYS, 31'd9, 8'd0, 1'b1, HERR_NONE, CERR_REPEATED, 16'd16);
      add_row(TYPE_TEXT, 31'd20, 8'd0, 1'b0, HERR_NONE, CERR_NONE, 16'd0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) send_chunk(directed_rows[i]);

      // Random chunks, mostly known types, with some near misses and noise.
      for (int i = 0; i < RANDOM_CHUNKS; i++) begin
         calm = ((i / 128) % 4 == 3);
         if (i == PAUSE_AT) begin
            @(negedge clock);
            req_valid <= 1'b0;
            while (expected_results.size() != 0) @(negedge clock);
         end
         row = '0;
         rnd = $urandom();
         row.clen = rnd[30:0];
         row.color = 8'($urandom_range(0, 255));
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            row.ctype = TYPE_IHDR;
            if ($urandom_range(0, 3) != 0) row.clen = HEADER_LENGTH;
            if ($urandom_range(0, 3) != 0) row.color = 8'($urandom_range(0, 7));
         end else if (pick < 22) begin
            row.ctype = TYPE_PLTE;
         end else if (pick < 45) begin
            row.ctype = TYPE_IDAT;
         end else if (pick < 75) begin
            case ($urandom_range(0, 6))
               0: row.ctype = TYPE_BKGD;
               1: row.ctype = TYPE_GAMA;
               2: row.ctype = TYPE_CHRM;
               3: row.ctype = TYPE_HIST;
               4: row.ctype = TYPE_PHYS;
               5: row.ctype = TYPE_TRNS;
               default: row.ctype = TYPE_SBIT;
            endcase
         end else if (pick < 85) begin
            // One bit away from a known type.
            row.ctype = (pick < 80 ? TYPE_IDAT : TYPE_IHDR) ^ (32'h1 << $urandom_range(0, 31));
         end else begin
            row.ctype = $urandom();
         end
         send_chunk(row);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (4) @(posedge clock);

      if (fail_count == 0) begin
         $display("** png_chunk_order_checker: PASSED **");
      end else begin
         $display("** png_chunk_order_checker: FAILED **");
      end
      $finish;
   end

endmodule
